// ===== design/bis_pkg.sv =====
// ============================================================================
// Bounded integer set package
// Operation codes and the update command shared by the set datapath modules.
// ============================================================================
package bis_pkg;

   // Width of one stored element and of the request value.
   localparam int unsigned ELEM_WIDTH  = 32;
   // Width of the count field in a response word.
   localparam int unsigned COUNT_WIDTH = 5;

   // Operation requested by an input word.
   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_ADD    = 2'd2,
      MODE_REMOVE = 2'd3
   } mode_type;

   // Update command from the decision logic to the element store.
   typedef struct packed {
      logic do_clear;   // drop every element
      logic do_append;  // write the value at the first free slot
      logic do_remove;  // close the gap left by the matching element
   } upd_type;

endpackage

// ===== design/bis_match.sv =====
// ============================================================================
// Bounded integer set match unit
// Compares the request value against every live element in parallel.
// ============================================================================
module bis_match
   import bis_pkg::*;
#(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
   input  logic [CAPACITY-1:0][ELEM_WIDTH-1:0] elements,
   input  logic [CW-1:0]                       count,
   input  logic [ELEM_WIDTH-1:0]               value,
   output logic                                match_any,
   output logic [CAPACITY-1:0]                 shift_mask
);

   logic [CAPACITY-1:0] match;

   // An entry takes part only if it lies below the fill count. Elements are
   // distinct, so at most one bit of match is set.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign match[i] = (CW'(i) < count) && (elements[i] == value);
      // Entries at and above the hit take their upper neighbor on a remove.
      assign shift_mask[i] = |match[i:0];
   end

   assign match_any = |match;

endmodule

// ===== design/bis_store.sv =====
// ============================================================================
// Bounded integer set element store
// Packed element registers and fill count, updated by append and close-gap.
// ============================================================================
module bis_store
   import bis_pkg::*;
#(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  upd_type                             upd,
   input  logic [ELEM_WIDTH-1:0]               value,
   input  logic [CAPACITY-1:0]                 shift_mask,
   output logic [CAPACITY-1:0][ELEM_WIDTH-1:0] elements,
   output logic [CW-1:0]                       count
);

   logic [CAPACITY-1:0][ELEM_WIDTH-1:0] elem_ff;
   logic [CAPACITY-1:0][ELEM_WIDTH-1:0] elem_in;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;

   always_comb begin
      elem_in = elem_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         if (upd.do_append && (CW'(i) == count_ff)) begin
            elem_in[i] = value;
         end else if (upd.do_remove && shift_mask[i] && (i + 1 < CAPACITY)) begin
            elem_in[i] = elem_ff[i + 1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (upd.do_clear) begin
         count_in = '0;
      end else if (upd.do_append) begin
         count_in = count_ff + CW'(1);
      end else if (upd.do_remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Element registers carry no reset: entries at or above the count are
   // never read.
   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign elements = elem_ff;
   assign count    = count_ff;

endmodule

// ===== design/bounded_integer_set.sv =====
// ============================================================================
// Bounded integer set
// Set of up to CAPACITY distinct 32-bit integers with clear, query, add and
// remove operations, one response word per request word.
// ============================================================================
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  req_mode, req_value
//   rsp_      out        rsp_valid / rsp_ready  rsp_found, rsp_status, rsp_count
//
// A request word is captured in an input register; once the response register
// is empty or being emptied, the parallel compare, the decision and the element
// update all complete in one pass, loading the response register. A word thus
// passes through the input register and then the response register before
// rsp_valid rises. One word is accepted every cycle while rsp_ready is high.
// The element update and the response load happen at the same edge, so the
// next word always sees the result of the previous one.
// Reset empties the set and drops any word in flight.
// When the response register is full and not taken, the input register holds
// and req_ready falls once it is occupied.
//
module bounded_integer_set
   import bis_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic               rsp_status,
   output logic [4:0]         rsp_count
);

   // Count width: the count must be able to hold CAPACITY itself.
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   // Input register.
   logic                  in_valid_ff;
   logic                  in_valid_in;
   mode_type              in_mode_ff;
   mode_type              in_mode_in;
   logic [ELEM_WIDTH-1:0] in_value_ff;
   logic [ELEM_WIDTH-1:0] in_value_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_found_ff;
   logic                   rsp_found_in;
   logic                   rsp_status_ff;
   logic                   rsp_status_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_in;

   logic                                advance;
   logic [CAPACITY-1:0][ELEM_WIDTH-1:0] elements;
   logic [CW-1:0]                       count;
   logic                                match_any;
   logic [CAPACITY-1:0]                 shift_mask;
   logic                                found;
   logic                                full;
   upd_type                             upd;
   logic [CW-1:0]                       count_next;
   logic [CW+COUNT_WIDTH-1:0]           count_ext;

   // The word in the input register is processed when the response register
   // is empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign in_mode_in  = (req_ready && req_valid) ? mode_type'(req_mode) : in_mode_ff;
   assign in_value_in = (req_ready && req_valid) ? req_value : in_value_ff;

   bis_match #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_match (
      .elements   (elements),
      .count      (count),
      .value      (in_value_ff),
      .match_any  (match_any),
      .shift_mask (shift_mask)
   );

   // Decision: clear never reports a hit; add is refused only when the value
   // is absent and the set is already at capacity.
   assign found = (in_mode_ff != MODE_CLEAR) && match_any;
   assign full  = (count == CW'(CAPACITY));

   always_comb begin
      upd.do_clear  = advance && (in_mode_ff == MODE_CLEAR);
      upd.do_append = advance && (in_mode_ff == MODE_ADD) && !found && !full;
      upd.do_remove = advance && (in_mode_ff == MODE_REMOVE) && found;
   end

   bis_store #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .value      (in_value_ff),
      .shift_mask (shift_mask),
      .elements   (elements),
      .count      (count)
   );

   // Count after the operation, as the store will hold it next cycle.
   always_comb begin
      count_next = count;
      if (upd.do_clear) begin
         count_next = '0;
      end else if (upd.do_append) begin
         count_next = count + CW'(1);
      end else if (upd.do_remove) begin
         count_next = count - CW'(1);
      end
   end

   // The reported count keeps only its low five bits for large capacities.
   assign count_ext = {{COUNT_WIDTH{1'b0}}, count_next};

   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_found_in  = advance ? found : rsp_found_ff;
   assign rsp_status_in = advance ? ((in_mode_ff == MODE_ADD) && !found && full)
                                  : rsp_status_ff;
   assign rsp_count_in  = advance ? count_ext[COUNT_WIDTH-1:0] : rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_mode_ff    <= in_mode_in;
      in_value_ff   <= in_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
